// ===== sv/failed_breakout_detector_core_macros.svh =====
// assertion helpers shared by the detector rtl
`ifndef FAILED_BREAKOUT_DETECTOR_CORE_MACROS_SVH
`define FAILED_BREAKOUT_DETECTOR_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define FBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define FBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/fbd_pkg.sv =====
package fbd_pkg;

  localparam int HISTORY_DEPTH = 32;
  localparam int AVG_BARS      = 10;
  localparam int PRICE_BITS    = 32;

  localparam int AVG_N   = (AVG_BARS > HISTORY_DEPTH) ? HISTORY_DEPTH : AVG_BARS;
  localparam int PTR_W   = $clog2(HISTORY_DEPTH);
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 2);
  localparam int IDX_W   = CNT_W + 1;
  localparam int SUM_W   = PRICE_BITS + $clog2(AVG_N + 1);
  localparam int RNG_MUL = AVG_N * 256;
  localparam int RP_W    = PRICE_BITS + $clog2(RNG_MUL + 1);
  localparam int MULT_W  = 16;
  localparam int SP_W    = SUM_W + MULT_W;
  localparam int CMP_W   = (RP_W > SP_W) ? RP_W : SP_W;

  localparam int LOOK_W  = 6;
  localparam int CNT8_W  = 8;

  // configuration register indexes
  localparam logic [1:0] REG_SWING_LOOKBACK   = 2'd0;
  localparam logic [1:0] REG_MAX_FAILURE_BARS = 2'd1;
  localparam logic [1:0] REG_RANGE_MULTIPLIER = 2'd2;
  localparam logic [1:0] REG_HIGHLIGHT_BARS   = 2'd3;

  // alert codes
  localparam logic [1:0] ALERT_NONE  = 2'd0;
  localparam logic [1:0] ALERT_LONG  = 2'd1;
  localparam logic [1:0] ALERT_SHORT = 2'd2;

  // breakout direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DECIDE
  } fbd_state_t;

endpackage

// ===== sv/failed_breakout_detector_core.sv =====
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+--------------------------------------
// in        | input     | in_valid / in_ready   | high_price, low_price, close_price
// out       | output    | out_valid / out_ready | long_trap, short_trap, alert_code
// cfg       | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// once history is warm a bar goes through scan, mul and decide, the scan reading n entries,
// n = max(lookback, averaging length); during warm-up a bar goes straight to decide
// the scan reads one history entry per cycle through the single read port of the ram
// rst is synchronous; history ram is not cleared, warm-up gating keeps unwritten slots unread
// a result beat waits in the output register; a stalled out channel holds the next bar in
// the decide step, while in_ready stays low until that bar is finished
`include "failed_breakout_detector_core_macros.svh"

module failed_breakout_detector_core
  import fbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // bar input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PRICE_BITS-1:0] high_price,
  input  logic [PRICE_BITS-1:0] low_price,
  input  logic [PRICE_BITS-1:0] close_price,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  long_trap,
  output logic                  short_trap,
  output logic [1:0]            alert_code,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [MULT_W-1:0]     cfg_data
);

  // configuration registers
  logic [LOOK_W-1:0] swing_lookback;
  logic [CNT8_W-1:0] max_failure_bars;
  logic [MULT_W-1:0] range_multiplier;
  logic [CNT8_W-1:0] highlight_bars;

  // control state
  fbd_state_t        state, state_next;
  logic [PTR_W-1:0]  wp;
  logic [CNT_W-1:0]  bars_seen;
  logic [CNT_W-1:0]  iss;
  logic              rd_pend;
  logic [CNT_W-1:0]  rd_k;
  logic              warm;
  logic [1:0]        dir;
  logic [CNT8_W-1:0] bars_since;
  logic [CNT8_W-1:0] long_hold;
  logic [CNT8_W-1:0] short_hold;

  // bar being worked on and scan results
  logic [PRICE_BITS-1:0] bar_hi, bar_lo, bar_cl;
  logic [PRICE_BITS-1:0] highest, lowest, level;
  logic [SUM_W-1:0]      sum;
  logic [RP_W-1:0]       prod_r;
  logic [SP_W-1:0]       prod_s;

  // ram interface
  logic                    rd_en, ram_we;
  logic [PTR_W-1:0]        raddr;
  logic [2*PRICE_BITS-1:0] rdata;

  // derived values
  logic [CNT_W-1:0]      look, n_scan;
  logic                  warm_now;
  logic [PRICE_BITS-1:0] rd_hi, rd_lo, rd_rng, bar_rng;
  logic                  wide, fire_long, fire_short, advance;
  logic [CNT8_W-1:0]     long_eff, short_eff;

  // effective lookback: zero acts as one, clipped to the history depth
  always_comb begin
    if (swing_lookback == '0) begin
      look = CNT_W'(1);
    end else if (int'(swing_lookback) > HISTORY_DEPTH) begin
      look = CNT_W'(HISTORY_DEPTH);
    end else begin
      look = CNT_W'(swing_lookback);
    end
    n_scan   = (look > CNT_W'(AVG_N)) ? look : CNT_W'(AVG_N);
    warm_now = (bars_seen >= look) && (bars_seen >= CNT_W'(AVG_N));
  end

  // read slot k bars back, wrapping around the ring
  assign raddr = (iss > CNT_W'(wp)) ?
                 PTR_W'(IDX_W'(wp) + IDX_W'(HISTORY_DEPTH) - IDX_W'(iss)) :
                 PTR_W'(IDX_W'(wp) - IDX_W'(iss));

  assign rd_hi   = rdata[2*PRICE_BITS-1:PRICE_BITS];
  assign rd_lo   = rdata[PRICE_BITS-1:0];
  // inverted bar counts as zero range
  assign rd_rng  = (rd_hi >= rd_lo) ? rd_hi - rd_lo : '0;
  assign bar_rng = (bar_hi >= bar_lo) ? bar_hi - bar_lo : '0;

  // failure test on the registered products
  assign wide       = CMP_W'(prod_r) > CMP_W'(prod_s);
  assign fire_long  = warm && wide && (bars_since <= max_failure_bars) &&
                      (dir == DIR_UP) && (bar_cl < level);
  assign fire_short = warm && wide && (bars_since <= max_failure_bars) &&
                      (dir == DIR_DOWN) && (bar_cl > level);
  assign advance    = !out_valid || out_ready;

  // longer hold wins
  assign long_eff  = (fire_long && (highlight_bars > long_hold)) ? highlight_bars : long_hold;
  assign short_eff = (fire_short && (highlight_bars > short_hold)) ? highlight_bars : short_hold;

  assign cfg_ready = 1'b1;

  fbd_ram #(
    .WIDTH (2 * PRICE_BITS),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata ({bar_hi, bar_lo}),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = warm_now ? ST_SCAN : ST_DECIDE;
        end
      end
      ST_SCAN: begin
        if (rd_pend && (rd_k == n_scan)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (advance) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    ram_we   = 1'b0;
    case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN:   rd_en    = (iss <= n_scan);
      ST_MUL:    rd_en    = 1'b0;
      ST_DECIDE: ram_we   = advance;
      default:   in_ready = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      wp               <= '0;
      bars_seen        <= '0;
      rd_pend          <= 1'b0;
      dir              <= DIR_NONE;
      bars_since       <= '0;
      long_hold        <= '0;
      short_hold       <= '0;
      out_valid        <= 1'b0;
      warm             <= 1'b0;
      swing_lookback   <= LOOK_W'(10);
      max_failure_bars <= CNT8_W'(3);
      range_multiplier <= MULT_W'(384);
      highlight_bars   <= CNT8_W'(5);
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SWING_LOOKBACK:   swing_lookback   <= cfg_data[LOOK_W-1:0];
          REG_MAX_FAILURE_BARS: max_failure_bars <= cfg_data[CNT8_W-1:0];
          REG_RANGE_MULTIPLIER: range_multiplier <= cfg_data;
          REG_HIGHLIGHT_BARS:   highlight_bars   <= cfg_data[CNT8_W-1:0];
          default:              highlight_bars   <= highlight_bars;
        endcase
      end

      // bar count since breakout saturates
      if (in_valid && in_ready) begin
        warm <= warm_now;
        if (bars_since != '1) begin
          bars_since <= bars_since + 1'b1;
        end
      end

      // breakout detection once the scan is done
      if (state == ST_MUL) begin
        if (bar_hi > highest) begin
          dir        <= DIR_UP;
          bars_since <= '0;
        end else if (bar_lo < lowest) begin
          dir        <= DIR_DOWN;
          bars_since <= '0;
        end
      end

      // finish the bar: result beat, holds, ring pointer
      if (state == ST_DECIDE && advance) begin
        out_valid  <= 1'b1;
        long_hold  <= (long_eff != '0) ? long_eff - 1'b1 : '0;
        short_hold <= (short_eff != '0) ? short_eff - 1'b1 : '0;
        if (fire_long || fire_short) begin
          dir <= DIR_NONE;
        end
        wp <= (int'(wp) == HISTORY_DEPTH - 1) ? '0 : wp + 1'b1;
        if (bars_seen < CNT_W'(HISTORY_DEPTH)) begin
          bars_seen <= bars_seen + 1'b1;
        end
      end else if (out_valid && out_ready) begin
        // beat taken with no new bar behind it
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      bar_hi  <= high_price;
      bar_lo  <= low_price;
      bar_cl  <= close_price;
      iss     <= CNT_W'(1);
      highest <= '0;
      lowest  <= '1;
      sum     <= '0;
    end

    if (rd_en) begin
      iss <= iss + 1'b1;
    end
    rd_k <= iss;

    // fold one history entry per cycle
    if (rd_pend) begin
      if (rd_k <= look) begin
        if (rd_hi > highest) begin
          highest <= rd_hi;
        end
        if (rd_lo < lowest) begin
          lowest <= rd_lo;
        end
      end
      if (rd_k <= CNT_W'(AVG_N)) begin
        sum <= sum + SUM_W'(rd_rng);
      end
    end

    // range test without division: range * n * 256 against sum * multiplier
    if (state == ST_MUL) begin
      prod_r <= RP_W'(bar_rng) * RP_W'(RNG_MUL);
      prod_s <= SP_W'(sum) * SP_W'(range_multiplier);
      if (bar_hi > highest) begin
        level <= highest;
      end else if (bar_lo < lowest) begin
        level <= lowest;
      end
    end

    if (state == ST_DECIDE && advance) begin
      long_trap  <= (long_eff != '0);
      short_trap <= (short_eff != '0);
      if (fire_long) begin
        alert_code <= ALERT_LONG;
      end else if (fire_short) begin
        alert_code <= ALERT_SHORT;
      end else begin
        alert_code <= ALERT_NONE;
      end
    end
  end

  // one bar at a time: no new bar right after one is taken
  `FBD_ASSERT_NEXT(a_one_bar, in_valid && in_ready, !in_ready, "bar accepted while busy")
  // each ring write advances the pointer by one slot
  `FBD_ASSERT_NEXT(a_wp_step, ram_we && (int'(wp) != HISTORY_DEPTH - 1), wp == PTR_W'($past(wp) + 1'b1), "write pointer did not advance")
  // read data only comes back from scan reads
  `FBD_ASSERT_NOW(a_rd_scan, rd_pend, $past(state) == ST_SCAN, "history data without scan read")
  // a fired failure clears the breakout direction
  `FBD_ASSERT_NEXT(a_dir_clr, (state == ST_DECIDE) && advance && (fire_long || fire_short), dir == DIR_NONE, "direction kept after failure")

endmodule

// ===== sv/fbd_ram.sv =====
module fbd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sim/tb_failed_breakout_detector_core.sv =====
module tb_failed_breakout_detector_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fbd_pkg::*;

  // one result beat as the block reports it
  typedef struct packed {
    logic       long_trap;
    logic       short_trap;
    logic [1:0] alert_code;
  } trap_result_t;

  // one row of the directed script; typed rows carry a hand-written result
  typedef struct packed {
    logic [PRICE_BITS-1:0] high_p;
    logic [PRICE_BITS-1:0] low_p;
    logic [PRICE_BITS-1:0] close_p;
    logic                  typed;
    trap_result_t          want;
  } bar_row_t;

  // how the two channels idle during a phase
  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_SLOW_SEND,
    PACE_SLOW_RECV,
    PACE_BOTH
  } pace_t;

  localparam trap_result_t NO_TRAP = '{1'b0, 1'b0, ALERT_NONE};
  localparam longint PRICE_MAX = longint'((64'd1 << PRICE_BITS) - 1);
  localparam int HEAVY_PCT = 88;
  localparam int LIGHT_PCT = 20;
  localparam int PHASES = 7;
  localparam int BARS_PER_PHASE = 230;
  localparam int TAIL_CYCLES = 40;
  localparam int STALL_LIMIT = 5000;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // bar channel
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PRICE_BITS-1:0] high_price = '0;
  logic [PRICE_BITS-1:0] low_price = '0;
  logic [PRICE_BITS-1:0] close_price = '0;

  // result channel
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       long_trap;
  logic       short_trap;
  logic [1:0] alert_code;

  // register write channel
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = REG_SWING_LOOKBACK;
  logic [MULT_W-1:0] cfg_data = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  failed_breakout_detector_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .high_price  (high_price),
    .low_price   (low_price),
    .close_price (close_price),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .long_trap   (long_trap),
    .short_trap  (short_trap),
    .alert_code  (alert_code),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // ------------------------------------------------------------------
  // predictor state: own copy of the bar history and breakout tracking
  // ------------------------------------------------------------------
  logic [PRICE_BITS-1:0] hist_hi [HISTORY_DEPTH];
  logic [PRICE_BITS-1:0] hist_lo [HISTORY_DEPTH];
  int unsigned           wr_slot = 0;
  int unsigned           seen_cnt = 0;
  logic [PRICE_BITS-1:0] level_q = '0;
  logic [1:0]            dir_q = DIR_NONE;
  int unsigned           since_cnt = 0;
  int unsigned           hold_long = 0;
  int unsigned           hold_short = 0;

  // register copies, reset values
  logic [LOOK_W-1:0] cfg_look = 6'd10;
  logic [7:0]        cfg_maxfail = 8'd3;
  logic [MULT_W-1:0] cfg_mult = 16'd384;
  logic [7:0]        cfg_highlight = 8'd5;

  // results still owed by the block, oldest first
  trap_result_t trap_queue [$];
  trap_result_t oldest_want;
  bar_row_t     script [$];

  int mismatch_count = 0;
  int beats_out = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  // stimulus generator state
  longint      gen_mid = 64'd2147483648;
  longint      gen_scale = 1000;
  int unsigned gen_quiet = 0;
  int unsigned gen_gap = 0;
  logic [1:0]  gen_trend = DIR_NONE;
  bit          gen_flat = 1'b0;

  // inverted bars count as zero range
  function automatic logic [63:0] bar_span(input logic [PRICE_BITS-1:0] h, l);
    return (h >= l) ? 64'(h - l) : 64'd0;
  endfunction

  function automatic logic [PRICE_BITS-1:0] to_price(input longint v);
    logic [PRICE_BITS-1:0] p;
    if (v < 0) p = '0;
    else if (v > PRICE_MAX) p = '1;
    else p = v[PRICE_BITS-1:0];
    return p;
  endfunction

  // advance the predictor by one bar and return the result it owes
  function automatic trap_result_t predict_bar(input logic [PRICE_BITS-1:0] h, l, c);
    int unsigned           look;
    int unsigned           slot;
    int unsigned           k;
    logic [PRICE_BITS-1:0] top;
    logic [PRICE_BITS-1:0] bottom;
    logic [63:0]           range_now;
    logic [63:0]           range_sum;
    logic [63:0]           lhs;
    logic [63:0]           rhs;
    trap_result_t          res;
    // lookback of zero acts as one, above depth acts as depth
    look = cfg_look;
    if (look == 0) look = 1;
    if (look > HISTORY_DEPTH) look = HISTORY_DEPTH;
    res.alert_code = ALERT_NONE;
    if (since_cnt < 255) since_cnt++;
    // nothing is detected until enough bars are in the history
    if (seen_cnt >= look && seen_cnt >= AVG_N) begin
      top = '0;
      bottom = '1;
      range_sum = '0;
      range_now = bar_span(h, l);
      for (k = 1; k <= look; k++) begin
        slot = (wr_slot + HISTORY_DEPTH - k) % HISTORY_DEPTH;
        if (hist_hi[slot] > top) top = hist_hi[slot];
        if (hist_lo[slot] < bottom) bottom = hist_lo[slot];
      end
      for (k = 1; k <= AVG_N; k++) begin
        slot = (wr_slot + HISTORY_DEPTH - k) % HISTORY_DEPTH;
        range_sum += bar_span(hist_hi[slot], hist_lo[slot]);
      end
      if (h > top) begin
        level_q = top;
        dir_q = DIR_UP;
        since_cnt = 0;
      end else if (l < bottom) begin
        level_q = bottom;
        dir_q = DIR_DOWN;
        since_cnt = 0;
      end
      // range expansion without division
      lhs = range_now * RNG_MUL;
      rhs = range_sum * cfg_mult;
      if (lhs > rhs && since_cnt <= cfg_maxfail) begin
        if (dir_q == DIR_UP && c < level_q) begin
          if (cfg_highlight > hold_long) hold_long = cfg_highlight;
          res.alert_code = ALERT_LONG;
          dir_q = DIR_NONE;
        end else if (dir_q == DIR_DOWN && c > level_q) begin
          if (cfg_highlight > hold_short) hold_short = cfg_highlight;
          res.alert_code = ALERT_SHORT;
          dir_q = DIR_NONE;
        end
      end
    end
    // flags show the hold before this bar uses up one count
    res.long_trap = (hold_long > 0);
    res.short_trap = (hold_short > 0);
    if (hold_long > 0) hold_long--;
    if (hold_short > 0) hold_short--;
    hist_hi[wr_slot] = h;
    hist_lo[wr_slot] = l;
    wr_slot = (wr_slot + 1) % HISTORY_DEPTH;
    if (seen_cnt < HISTORY_DEPTH) seen_cnt++;
    return res;
  endfunction

  task automatic add_row(input logic [PRICE_BITS-1:0] h, l, c, input logic typed);
    script.push_back('{h, l, c, typed, NO_TRAP});
  endtask

  task automatic set_pace(input pace_t pace);
    case (pace)
      PACE_FREE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      PACE_SLOW_SEND: begin
        send_idle_pct = HEAVY_PCT;
        recv_stall_pct = 0;
      end
      PACE_SLOW_RECV: begin
        send_idle_pct = 0;
        recv_stall_pct = HEAVY_PCT;
      end
      default: begin
        send_idle_pct = LIGHT_PCT;
        recv_stall_pct = LIGHT_PCT;
      end
    endcase
  endtask

  // one register write beat; valid stays up for a following write
  task automatic write_reg(input logic [1:0] idx, input logic [MULT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SWING_LOOKBACK:   cfg_look = data[LOOK_W-1:0];
      REG_MAX_FAILURE_BARS: cfg_maxfail = data[7:0];
      REG_RANGE_MULTIPLIER: cfg_mult = data;
      REG_HIGHLIGHT_BARS:   cfg_highlight = data[7:0];
      default: ;
    endcase
  endtask

  // writes all four registers; unused upper bits carry junk
  task automatic program_regs(input logic [LOOK_W-1:0] look, input logic [7:0] max_bars,
                              input logic [MULT_W-1:0] mult, input logic [7:0] hold);
    logic [MULT_W-1:0] junk;
    junk = MULT_W'($urandom);
    write_reg(REG_SWING_LOOKBACK, {junk[MULT_W-1:LOOK_W], look});
    write_reg(REG_MAX_FAILURE_BARS, {junk[MULT_W-1:8], max_bars});
    write_reg(REG_RANGE_MULTIPLIER, mult);
    write_reg(REG_HIGHLIGHT_BARS, {junk[7:0], hold});
    cfg_valid <= 1'b0;
  endtask

  // one bar beat; the result owed is queued at the accepting edge
  task automatic send_bar(input logic [PRICE_BITS-1:0] h, l, c, input logic typed,
                          input trap_result_t typed_want);
    trap_result_t model_res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    high_price <= h;
    low_price <= l;
    close_price <= c;
    do @(posedge clk); while (!in_ready);
    // predictor always advances, even where the row gives the answer
    model_res = predict_bar(h, l, c);
    trap_queue.push_back(typed ? typed_want : model_res);
  endtask

  task automatic drain_results();
    while (trap_queue.size() != 0) @(posedge clk);
  endtask

  // builds a market-like bar: quiet drift, breakout, pause, reversal, plus noise
  task automatic next_bar(output logic [PRICE_BITS-1:0] h, l, c);
    longint hv;
    longint lv;
    longint cv;
    longint half;
    longint w;
    half = gen_scale / 2;
    if (!gen_flat && $urandom_range(0, 99) < 8) begin
      // full-width noise, inverted bars included
      hv = longint'($urandom);
      lv = longint'($urandom);
      cv = longint'($urandom);
    end else if (gen_trend == DIR_NONE && gen_quiet > 0) begin
      gen_mid = gen_mid + longint'($urandom_range(0, 2 * gen_scale)) - gen_scale;
      if (gen_mid < 0) gen_mid = 0;
      if (gen_mid > PRICE_MAX) gen_mid = PRICE_MAX;
      w = longint'($urandom_range(1, gen_scale));
      hv = gen_mid + w / 2;
      lv = hv - w;
      cv = lv + longint'($urandom_range(0, w));
      gen_quiet--;
    end else if (gen_trend == DIR_NONE) begin
      // breakout bar; sometimes it closes back inside at once
      if ($urandom_range(0, 1) == 0) begin
        gen_trend = DIR_UP;
        hv = gen_mid + gen_scale * longint'($urandom_range(2, 5));
        lv = gen_mid - half;
        cv = ($urandom_range(0, 3) == 0) ? gen_mid - gen_scale
                                         : hv - longint'($urandom_range(0, gen_scale));
      end else begin
        gen_trend = DIR_DOWN;
        lv = gen_mid - gen_scale * longint'($urandom_range(2, 5));
        hv = gen_mid + half;
        cv = ($urandom_range(0, 3) == 0) ? gen_mid + gen_scale
                                         : lv + longint'($urandom_range(0, gen_scale));
      end
      // rare flat stretch long enough to saturate the bar count
      if ($urandom_range(0, 24) == 0) begin
        gen_gap = $urandom_range(256, 280);
        gen_flat = 1'b1;
      end else begin
        gen_gap = $urandom_range(0, 5);
        gen_flat = 1'b0;
      end
    end else if (gen_gap > 0) begin
      if (!gen_flat) begin
        gen_mid = gen_mid + longint'($urandom_range(0, gen_scale)) - half;
        if (gen_mid < 0) gen_mid = 0;
        if (gen_mid > PRICE_MAX) gen_mid = PRICE_MAX;
      end
      w = gen_flat ? 2 * half : longint'($urandom_range(1, gen_scale));
      hv = gen_mid + w / 2;
      lv = hv - w;
      cv = lv + longint'($urandom_range(0, w));
      gen_gap--;
    end else begin
      // wide reversal back through the level
      if (gen_trend == DIR_UP) begin
        cv = gen_mid - gen_scale * longint'($urandom_range(1, 3));
        lv = cv - longint'($urandom_range(0, gen_scale));
        hv = gen_mid + half;
      end else begin
        cv = gen_mid + gen_scale * longint'($urandom_range(1, 3));
        hv = cv + longint'($urandom_range(0, gen_scale));
        lv = gen_mid - half;
      end
      gen_trend = DIR_NONE;
      gen_flat = 1'b0;
      gen_quiet = $urandom_range(0, 14);
      if ($urandom_range(0, 9) == 0) gen_scale = $urandom_range(1, 1 << $urandom_range(0, 20));
      if ($urandom_range(0, 19) == 0) gen_mid = longint'($urandom);
    end
    h = to_price(hv);
    l = to_price(lv);
    c = to_price(cv);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: result beat %0d %s mismatch: expected %0d actual %0d",
               $time, beats_out, name, want, got);
      mismatch_count++;
    end
  endtask

  // result side: random ready, compare every accepted beat with the oldest owed
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (trap_queue.size() == 0) begin
        $display("%0t: unexpected result beat: expected none actual long %0b short %0b alert %0d",
                 $time, long_trap, short_trap, alert_code);
        mismatch_count++;
      end else begin
        oldest_want = trap_queue.pop_front();
        check_field("long_trap", oldest_want.long_trap, long_trap);
        check_field("short_trap", oldest_want.short_trap, short_trap);
        check_field("alert_code", oldest_want.alert_code, alert_code);
      end
      beats_out++;
    end
  end

  // watchdog: any beat on any channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [PRICE_BITS-1:0] h;
    logic [PRICE_BITS-1:0] l;
    logic [PRICE_BITS-1:0] c;
    int                    n;
    for (n = 0; n < HISTORY_DEPTH; n++) begin
      hist_hi[n] = '0;
      hist_lo[n] = '0;
    end

    // directed script on reset register values (10, 3, 384, 5)
    // warm-up: price extremes and an inverted bar, nothing detected yet
    add_row('1, '0, '1, 1'b1);
    add_row('0, '0, '0, 1'b1);
    add_row('0, '1, 32'h8000_0000, 1'b1);
    for (n = 3; n < 13; n++) add_row(1005, 995, 1000, (n < 10));
    // upside breakout that fails on the same bar
    add_row(1100, 990, 1000, 1'b0);
    add_row(1005, 995, 1000, 1'b0);
    // downside breakout, then a wide bar closing back above the level
    add_row(1002, 900, 950, 1'b0);
    add_row(1005, 995, 1000, 1'b0);
    add_row(1100, 960, 1050, 1'b0);
    // upside breakout whose reversal comes too late
    add_row(1200, 1090, 1150, 1'b0);
    for (n = 0; n < 4; n++) add_row(1155, 1145, 1150, 1'b0);
    add_row(1160, 1000, 1010, 1'b0);
    // inverted bar once detection is live
    add_row('0, '1, '0, 1'b0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    set_pace(PACE_FREE);
    for (n = 0; n < script.size(); n++) begin
      send_bar(script[n].high_p, script[n].low_p, script[n].close_p,
               script[n].typed, script[n].want);
    end
    in_valid <= 1'b0;

    // random phases; each one programs the registers and picks a pacing
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0:       program_regs(6'd1, 8'd0, 16'd0, 8'd0);
        1:       program_regs(6'd32, 8'd255, 16'hFFFF, 8'd255);
        2:       program_regs(6'd63, 8'd255, 16'd256, 8'd1);
        3:       program_regs(6'd0, 8'd10, 16'd384, 8'd20);
        5:       program_regs(6'd5, 8'd1, 16'd512, 8'd3);
        default: program_regs(LOOK_W'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                              MULT_W'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      endcase
      set_pace(pace_t'(phase % 4));
      for (n = 0; n < BARS_PER_PHASE; n++) begin
        next_bar(h, l, c);
        send_bar(h, l, c, 1'b0, NO_TRAP);
      end
      in_valid <= 1'b0;
    end

    // let every owed result come out, then watch for strays
    set_pace(PACE_FREE);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
